FILE: sv/window_cooccurrence_pair_generator_core_defines.svh
// Assertion macros used by the pair generator back end.
`ifndef WINDOW_COOCCURRENCE_PAIR_GENERATOR_CORE_DEFINES_SVH
`define WINDOW_COOCCURRENCE_PAIR_GENERATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define WCPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define WCPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/wcpg_pkg.sv
// Shared constants, types and tables of the pair generator.
package wcpg_pkg;

  localparam int MAX_WINDOW = 16;
  localparam int RANK_BITS  = 20;
  localparam int SLOT_BITS  = $clog2(MAX_WINDOW);
  localparam int CNT_BITS   = $clog2(MAX_WINDOW + 1);
  localparam int PROD_BITS  = 2 * (RANK_BITS + 1);
  localparam int LIMIT_BITS = 41;
  localparam int WIN_BITS   = 5;
  localparam int DIST_BITS  = 5;
  localparam int WEIGHT_BITS = 17;
  localparam int QDEPTH     = 2;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_BITS = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_LEN     = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SYMMETRIC   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DENSE_LIMIT = 2'd2;

  localparam logic [WIN_BITS-1:0]   WINDOW_RESET = 5'd10;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = 41'd1048576;

  // One word waiting for the back end
  typedef struct packed {
    logic [RANK_BITS-1:0] rank;
    logic [CNT_BITS-1:0]  pairs;
    logic [SLOT_BITS-1:0] slot;
  } cmd_t;

  // Settings the back end needs
  typedef struct packed {
    logic                  symmetric;
    logic [LIMIT_BITS-1:0] dense_limit;
  } back_cfg_t;

  // floor(65536 / d) for d in 1..16
  function automatic logic [WEIGHT_BITS-1:0] weight_of(input logic [DIST_BITS-1:0] d);
    logic [WEIGHT_BITS-1:0] w;
    w = '0;
    unique case (d)
      5'd1:    w = 17'd65536;
      5'd2:    w = 17'd32768;
      5'd3:    w = 17'd21845;
      5'd4:    w = 17'd16384;
      5'd5:    w = 17'd13107;
      5'd6:    w = 17'd10922;
      5'd7:    w = 17'd9362;
      5'd8:    w = 17'd8192;
      5'd9:    w = 17'd7281;
      5'd10:   w = 17'd6553;
      5'd11:   w = 17'd5957;
      5'd12:   w = 17'd5461;
      5'd13:   w = 17'd5041;
      5'd14:   w = 17'd4681;
      5'd15:   w = 17'd4369;
      5'd16:   w = 17'd4096;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

FILE: sv/wcpg_front.sv
// Front end: accepts words and line ends, tracks line position, queues work.
module wcpg_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [wcpg_pkg::RANK_BITS-1:0] word_rank,
  input  logic [wcpg_pkg::WIN_BITS-1:0] win_len,
  output logic                          push,
  output wcpg_pkg::cmd_t                push_cmd,
  input  logic                          full
);

  logic [wcpg_pkg::CNT_BITS-1:0]  words;
  logic [wcpg_pkg::SLOT_BITS-1:0] slot;
  logic [wcpg_pkg::CNT_BITS-1:0]  eff_window;
  logic                           take;

  assign in_ready = !full;
  assign take     = in_valid && in_ready;
  assign push     = take && !action;

  // Clamp window to 1..MAX_WINDOW
  always_comb begin
    if (win_len == '0) begin
      eff_window = wcpg_pkg::CNT_BITS'(1);
    end else if (wcpg_pkg::CNT_BITS'(win_len) >
                 wcpg_pkg::CNT_BITS'(wcpg_pkg::MAX_WINDOW)) begin
      eff_window = wcpg_pkg::CNT_BITS'(wcpg_pkg::MAX_WINDOW);
    end else begin
      eff_window = wcpg_pkg::CNT_BITS'(win_len);
    end
  end

  // Pair count is the window cut to the words seen so far in the line
  always_comb begin
    push_cmd.rank  = word_rank;
    push_cmd.pairs = (eff_window > words) ? words : eff_window;
    push_cmd.slot  = slot;
  end

  // Advance line position on a word, clear it on a line end
  always_ff @(posedge clk) begin
    if (rst) begin
      words <= '0;
      slot  <= '0;
    end else if (take) begin
      if (action) begin
        words <= '0;
        slot  <= '0;
      end else begin
        slot <= slot + 1'b1;
        if (words < wcpg_pkg::CNT_BITS'(wcpg_pkg::MAX_WINDOW)) begin
          words <= words + 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/wcpg_queue.sv
// Short command queue between front and back ends.
module wcpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wcpg_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output wcpg_pkg::cmd_t head,
  output logic           empty
);

  wcpg_pkg::cmd_t                  entries [wcpg_pkg::QDEPTH];
  logic [wcpg_pkg::QPTR_BITS-1:0]  wr_ptr;
  logic [wcpg_pkg::QPTR_BITS-1:0]  rd_ptr;
  logic [wcpg_pkg::QCNT_BITS-1:0]  count;

  assign full  = (count == wcpg_pkg::QCNT_BITS'(wcpg_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store entry on a push
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/wcpg_back.sv
// Back end: walks the history ring per word and emits pair records.
`include "window_cooccurrence_pair_generator_core_defines.svh"

module wcpg_back (
  input  logic                             clk,
  input  logic                             rst,
  input  wcpg_pkg::back_cfg_t              cfg,
  input  wcpg_pkg::cmd_t                   head,
  input  logic                             empty,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [wcpg_pkg::RANK_BITS-1:0]   center_word,
  output logic [wcpg_pkg::RANK_BITS-1:0]   context_word,
  output logic [wcpg_pkg::DIST_BITS-1:0]   distance,
  output logic [wcpg_pkg::WEIGHT_BITS-1:0] weight_q16,
  output logic                             dense,
  output logic                             last
);

  // History ring of the current line
  logic [wcpg_pkg::RANK_BITS-1:0] ring [wcpg_pkg::MAX_WINDOW];
  logic                           ring_we;
  logic [wcpg_pkg::SLOT_BITS-1:0] ring_waddr;
  logic [wcpg_pkg::RANK_BITS-1:0] ring_wdata;
  logic [wcpg_pkg::SLOT_BITS-1:0] ring_raddr;

  // Issue stage
  logic                           act;
  logic [wcpg_pkg::RANK_BITS-1:0] c_rank;
  logic [wcpg_pkg::SLOT_BITS-1:0] c_slot;
  logic [wcpg_pkg::CNT_BITS-1:0]  c_d;

  // Ring read stage
  logic                           s1_valid;
  logic [wcpg_pkg::RANK_BITS-1:0] s1_center;
  logic [wcpg_pkg::RANK_BITS-1:0] s1_w2;
  logic [wcpg_pkg::DIST_BITS-1:0] s1_d;
  logic                           s1_lastpair;

  // Product stage
  logic                           s2_valid;
  logic [wcpg_pkg::RANK_BITS-1:0] s2_center;
  logic [wcpg_pkg::RANK_BITS-1:0] s2_w2;
  logic [wcpg_pkg::DIST_BITS-1:0] s2_d;
  logic                           s2_lastpair;
  logic [wcpg_pkg::PROD_BITS-1:0] s2_prod;

  // Output stage
  logic twin_todo;
  logic twin_last;
  logic advance;
  logic issue_last;

  assign advance    = !out_valid || (out_ready && !twin_todo);
  assign pop        = !act && !empty;
  assign issue_last = advance && act && (c_d == wcpg_pkg::CNT_BITS'(1));
  assign ring_raddr = c_slot - c_d[wcpg_pkg::SLOT_BITS-1:0];

  // Write a word into the ring once its pairs have all been read, or on load if it has none
  always_comb begin
    if (issue_last) begin
      ring_we    = 1'b1;
      ring_waddr = c_slot;
      ring_wdata = c_rank;
    end else begin
      ring_we    = pop && (head.pairs == '0);
      ring_waddr = head.slot;
      ring_wdata = head.rank;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_waddr] <= ring_wdata;
    end
  end

  // Load a command, then count distance down to one
  always_ff @(posedge clk) begin
    if (rst) begin
      act <= 1'b0;
    end else if (pop) begin
      act <= (head.pairs != '0);
    end else if (issue_last) begin
      act <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      c_rank <= head.rank;
      c_slot <= head.slot;
      c_d    <= head.pairs;
    end else if (advance && act) begin
      c_d <= c_d - 1'b1;
    end
  end

  // Advance the read and product stages together
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= act;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_center   <= c_rank;
      s1_w2       <= ring[ring_raddr];
      s1_d        <= wcpg_pkg::DIST_BITS'(c_d);
      s1_lastpair <= (c_d == wcpg_pkg::CNT_BITS'(1));
      s2_center   <= s1_center;
      s2_w2       <= s1_w2;
      s2_d        <= s1_d;
      s2_lastpair <= s1_lastpair;
      s2_prod     <= wcpg_pkg::PROD_BITS'({1'b0, s1_center} + 1'b1)
                   * wcpg_pkg::PROD_BITS'({1'b0, s1_w2} + 1'b1);
    end
  end

  // Hold the record until transfer, then show its twin if owed
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      twin_todo <= 1'b0;
    end else if (advance) begin
      out_valid <= s2_valid;
      twin_todo <= s2_valid && cfg.symmetric;
    end else if (out_ready && twin_todo) begin
      twin_todo <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      center_word  <= s2_center;
      context_word <= s2_w2;
      distance     <= s2_d;
      dense        <= (s2_prod <= wcpg_pkg::PROD_BITS'(cfg.dense_limit));
      last         <= s2_lastpair && !cfg.symmetric;
      twin_last    <= s2_lastpair;
    end else if (out_ready && twin_todo) begin
      center_word  <= context_word;
      context_word <= center_word;
      last         <= twin_last;
    end
  end

  assign weight_q16 = wcpg_pkg::weight_of(distance);

  `WCPG_ASSERT_NOW(a_twin_needs_sym, out_valid && twin_todo, cfg.symmetric, "twin owed in one-sided mode")
  `WCPG_ASSERT_NOW(a_dist_range, out_valid, (distance != '0) && (distance <= wcpg_pkg::DIST_BITS'(wcpg_pkg::MAX_WINDOW)), "distance out of range")
  `WCPG_ASSERT_NOW(a_issue_nonzero, act, c_d != '0, "issue with zero distance")
  `WCPG_ASSERT_NEXT(a_twin_swapped, out_valid && out_ready && twin_todo, out_valid && (center_word == $past(context_word)) && (context_word == $past(center_word)), "twin not swapped")

endmodule

FILE: sv/window_cooccurrence_pair_generator_core.sv
// Path: a word is queued, loaded into the issue stage, then passes the ring read,
// product and output stages. One record per cycle while out_ready holds; when
// symmetric the queue load hides under a twin, one-sided it leaves a gap per word.
// Defaults: window 10, symmetric.
// Reset: line position, queue and pipeline cleared, registers to defaults;
// the history ring is not cleared and is read only after being written.
module window_cooccurrence_pair_generator_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 action,
  input  logic [wcpg_pkg::RANK_BITS-1:0]       word_rank,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [wcpg_pkg::RANK_BITS-1:0]       center_word,
  output logic [wcpg_pkg::RANK_BITS-1:0]       context_word,
  output logic [wcpg_pkg::DIST_BITS-1:0]       distance,
  output logic [wcpg_pkg::WEIGHT_BITS-1:0]     weight_q16,
  output logic                                 dense,
  output logic                                 last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wcpg_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [wcpg_pkg::LIMIT_BITS-1:0]      cfg_data
);

  logic [wcpg_pkg::WIN_BITS-1:0] win_len;
  wcpg_pkg::back_cfg_t           back_cfg;
  logic                          push;
  wcpg_pkg::cmd_t                push_cmd;
  logic                          full;
  logic                          pop;
  wcpg_pkg::cmd_t                head;
  logic                          empty;

  assign cfg_ready = 1'b1;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len               <= wcpg_pkg::WINDOW_RESET;
      back_cfg.symmetric    <= 1'b1;
      back_cfg.dense_limit  <= wcpg_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wcpg_pkg::CFG_WIN_LEN:     win_len <= cfg_data[wcpg_pkg::WIN_BITS-1:0];
        wcpg_pkg::CFG_SYMMETRIC:   back_cfg.symmetric <= cfg_data[0];
        wcpg_pkg::CFG_DENSE_LIMIT: back_cfg.dense_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  wcpg_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .word_rank   (word_rank),
    .win_len     (win_len),
    .push        (push),
    .push_cmd    (push_cmd),
    .full        (full)
  );

  wcpg_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  wcpg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (back_cfg),
    .head         (head),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .center_word  (center_word),
    .context_word (context_word),
    .distance     (distance),
    .weight_q16   (weight_q16),
    .dense        (dense),
    .last         (last)
  );

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the window co-occurrence pair generator core.
module tb;
  import wcpg_pkg::*;

  localparam logic ACT_WORD     = 1'b0;
  localparam logic ACT_LINE_END = 1'b1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = {LIMIT_BITS{1'b1}};
  localparam logic [RANK_BITS-1:0] RANK_MAX = {RANK_BITS{1'b1}};

  typedef struct packed {
    logic [RANK_BITS-1:0]   center;
    logic [RANK_BITS-1:0]   neighbor;
    logic [DIST_BITS-1:0]   gap;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   is_dense;
    logic                   is_last;
  } pair_rec_t;

  // Line history and settings, mirrored to predict the pair records of each word
  class pair_tracker;
    logic [RANK_BITS-1:0]  ring [MAX_WINDOW];
    int unsigned           line_len;
    int unsigned           wr_slot;
    logic [WIN_BITS-1:0]   win;
    logic                  sym;
    logic [LIMIT_BITS-1:0] limit;
    pair_rec_t             pending[$];
    int unsigned           bad;

    function new();
      line_len = 0;
      wr_slot = 0;
      win = WINDOW_RESET;
      sym = 1'b1;
      limit = LIMIT_RESET;
      bad = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [LIMIT_BITS-1:0] data);
      case (idx)
        CFG_WIN_LEN:     win = data[WIN_BITS-1:0];
        CFG_SYMMETRIC:   sym = data[0];
        CFG_DENSE_LIMIT: limit = data;
        default: ;
      endcase
    endfunction

    // Note an accepted token and queue the records it produces
    function void take_token(logic act, logic [RANK_BITS-1:0] rank);
      int unsigned n;
      int unsigned slot;
      int d;
      logic [RANK_BITS-1:0] other;
      logic hit;
      pair_rec_t r;
      if (act == ACT_LINE_END) begin
        line_len = 0;
        wr_slot = 0;
        return;
      end
      n = (win == 0) ? 1 : ((win > MAX_WINDOW) ? MAX_WINDOW : win);
      if (n > line_len) n = line_len;
      // Walk the history oldest first
      for (d = n; d >= 1; d--) begin
        slot = (wr_slot + MAX_WINDOW - d) % MAX_WINDOW;
        other = ring[slot];
        hit = (64'(rank) + 64'd1) <= (64'(limit) / (64'(other) + 64'd1));
        r.center = rank;
        r.neighbor = other;
        r.gap = DIST_BITS'(d);
        r.weight = WEIGHT_BITS'(65536 / d);
        r.is_dense = hit;
        r.is_last = (d == 1) && !sym;
        pending.push_back(r);
        if (sym) begin
          r.center = other;
          r.neighbor = rank;
          r.is_last = (d == 1);
          pending.push_back(r);
        end
      end
      ring[wr_slot] = rank;
      wr_slot = (wr_slot + 1) % MAX_WINDOW;
      if (line_len < MAX_WINDOW) line_len++;
    endfunction

    // Compare one transferred record with the oldest prediction
    function void check_record(pair_rec_t got);
      pair_rec_t want;
      if (pending.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display({"unexpected record: center=%0d context=%0d distance=%0d",
                    " weight=%0d dense=%0b last=%0b"},
                   got.center, got.neighbor, got.gap, got.weight, got.is_dense,
                   got.is_last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        bad++;
        if (bad <= 10) begin
          $display("record mismatch at %0t", $realtime);
          $display({"  expected center=%0d context=%0d distance=%0d",
                    " weight=%0d dense=%0b last=%0b"},
                   want.center, want.neighbor, want.gap, want.weight, want.is_dense,
                   want.is_last);
          $display({"  actual   center=%0d context=%0d distance=%0d",
                    " weight=%0d dense=%0b last=%0b"},
                   got.center, got.neighbor, got.gap, got.weight, got.is_dense,
                   got.is_last);
        end
      end
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   action;
  logic [RANK_BITS-1:0]   word_rank;
  logic                   out_valid;
  logic                   out_ready;
  logic [RANK_BITS-1:0]   center_word;
  logic [RANK_BITS-1:0]   context_word;
  logic [DIST_BITS-1:0]   distance;
  logic [WEIGHT_BITS-1:0] weight_q16;
  logic                   dense;
  logic                   last;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [LIMIT_BITS-1:0]  cfg_data;

  pair_tracker trk;
  int idle_pct;
  int stall_pct;

  window_cooccurrence_pair_generator_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up after a generous bound
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Accept records with random back-pressure and check each transfer
  initial begin : rx
    pair_rec_t got;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.center = center_word;
        got.neighbor = context_word;
        got.gap = distance;
        got.weight = weight_q16;
        got.is_dense = dense;
        got.is_last = last;
        trk.check_record(got);
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Present one token, idling first as the phase asks, and hold until transfer
  task automatic send_token(logic act, logic [RANK_BITS-1:0] rank);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    word_rank <= rank;
    do @(posedge clk); while (!in_ready);
    trk.take_token(act, rank);
  endtask

  // Hold input until every record is out, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (trk.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [LIMIT_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    trk.set_reg(idx, data);
  endtask

  // Load all registers; junk in the unused upper bits must be dropped
  task automatic set_regs(logic [WIN_BITS-1:0] w, logic s, logic [LIMIT_BITS-1:0] lim,
                          bit poke_unused);
    logic [LIMIT_BITS-1:0] junk;
    junk = LIMIT_BITS'({$urandom, $urandom});
    if (poke_unused) write_reg(CFG_UNUSED, junk);
    write_reg(CFG_WIN_LEN, {junk[LIMIT_BITS-1:WIN_BITS], w});
    write_reg(CFG_SYMMETRIC, {junk[LIMIT_BITS-2:0], s});
    write_reg(CFG_DENSE_LIMIT, lim);
    cfg_valid <= 1'b0;
  endtask

  initial begin : main
    int seg;
    int n;
    logic [WIN_BITS-1:0] w;
    logic [LIMIT_BITS-1:0] lim;
    logic [RANK_BITS-1:0] rank;
    logic act;

    trk = new();
    idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_WORD;
    word_rank = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIN_LEN;
    cfg_data = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty line end, first word, rank extremes, dense edge
    send_token(ACT_LINE_END, RANK_MAX);
    send_token(ACT_WORD, '0);
    send_token(ACT_WORD, RANK_MAX);
    send_token(ACT_WORD, RANK_MAX);
    send_token(ACT_WORD, 20'd5);
    send_token(ACT_LINE_END, 20'd9);
    send_token(ACT_LINE_END, '0);
    send_token(ACT_WORD, 20'd7);
    send_token(ACT_WORD, '0);
    settle();

    // Window zero, one-sided, limit zero, changed mid-line
    set_regs('0, 1'b0, '0, 1'b1);
    send_token(ACT_WORD, 20'd3);
    send_token(ACT_WORD, RANK_MAX);
    send_token(ACT_WORD, 20'd1);
    settle();

    // Oversized window, top limit; run the line past the ring depth
    set_regs(5'd31, 1'b1, LIMIT_MAX, 1'b0);
    for (n = 0; n < 13; n++)
      send_token(ACT_WORD, n[0] ? RANK_MAX : RANK_BITS'($urandom));
    settle();

    // Random segments across the idle and back-pressure phases
    for (seg = 0; seg < 8; seg++) begin
      case (seg % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 32; stall_pct = 32; end
      endcase
      case ($urandom_range(4))
        0: w = '0;
        1: w = WIN_BITS'(MAX_WINDOW);
        2: w = WIN_BITS'($urandom_range(31, 17));
        default: w = WIN_BITS'($urandom_range(1, 16));
      endcase
      case ($urandom_range(5))
        0: lim = '0;
        1: lim = LIMIT_MAX;
        2: lim = LIMIT_BITS'($urandom_range(300));
        3: lim = LIMIT_RESET + LIMIT_BITS'($urandom_range(1 << 20));
        default: lim = LIMIT_BITS'({$urandom, $urandom});
      endcase
      set_regs(w, 1'($urandom_range(1)), lim, 1'($urandom_range(1)));

      for (n = 0; n < 44; n++) begin
        // Now and then drain everything before the next token
        if ($urandom_range(39) == 0 && trk.pending.size() != 0) begin
          in_valid <= 1'b0;
          while (trk.pending.size() != 0) @(posedge clk);
        end
        act = ($urandom_range(11) == 0) ? ACT_LINE_END : ACT_WORD;
        case ($urandom_range(3))
          0: rank = RANK_BITS'($urandom_range(15));
          1: rank = RANK_MAX - RANK_BITS'($urandom_range(15));
          default: rank = RANK_BITS'($urandom);
        endcase
        send_token(act, rank);
      end
      settle();
    end

    if (trk.bad == 0 && trk.pending.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/wcpg_pkg.sv
sv/wcpg_front.sv
sv/wcpg_queue.sv
sv/wcpg_back.sv
sv/window_cooccurrence_pair_generator_core.sv
sim/tb.sv
